[rtl/core/thp_pkg.sv]
package thp_pkg;

	// Default port widths
	localparam int DEF_INPUT_WIDTH  = 16;
	localparam int DEF_OUTPUT_WIDTH = 16;

	// Gain register, signed Q4.12
	localparam int GAIN_W = 16;
	localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd4096;

	// Internal fixed point: 16 fraction bits throughout
	localparam int FRAC = 16;

	// Scaled product p = round(x * gain) in Q.16 always fits 25 bits
	localparam int P_W = 25;

	// pi in Q2.28
	localparam int PI_W     = 31;
	localparam int PI_SHIFT = 28;
	localparam logic signed [PI_W-1:0] PI_Q28 = 31'sd843314857;
	localparam int TP_W = P_W + PI_W;

	// Polynomial argument t in Q.16
	localparam int T_W = 28;

	// Horner accumulator saturates at +-2^36 raw
	localparam int ACC_LIM_EXP = 36;
	localparam int ACC_W       = ACC_LIM_EXP + 2;
	localparam logic signed [ACC_W-1:0] ACC_LIMIT = ACC_W'(64'sd1 <<< ACC_LIM_EXP);

	// Clamped value is within +-1.0 in Q.16
	localparam int CLAMP_W = FRAC + 2;
	localparam logic signed [CLAMP_W-1:0] ONE_Q16 = CLAMP_W'(64'sd1 <<< FRAC);

	// Coefficients in Q.16, highest power first
	localparam int POLY_ORDER = 9;
	typedef logic signed [ACC_W-1:0] coef_t;
	localparam coef_t COEF_TABLE [0:POLY_ORDER] = '{
		38'sd290146, 38'sd0, -38'sd811852, 38'sd0, 38'sd878789,
		38'sd0, -38'sd490460, 38'sd0, 38'sd199374, 38'sd0
	};

endpackage

[rtl/core/thp_stream_if.sv]
interface thp_sample_if #(
	parameter int WIDTH = thp_pkg::DEF_INPUT_WIDTH
) ();
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface thp_act_if #(
	parameter int WIDTH = thp_pkg::DEF_OUTPUT_WIDTH
) ();
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] act_out;

	modport source (output valid, output act_out, input ready);
	modport sink   (input valid, input act_out, output ready);
endinterface

[rtl/core/thp_scale.sv]
module thp_scale #(
	parameter int INPUT_WIDTH = thp_pkg::DEF_INPUT_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic                              valid_in,
	input  logic signed [INPUT_WIDTH-1:0]     sample,
	input  logic signed [thp_pkg::GAIN_W-1:0] gain,
	output logic                              valid_out,
	output logic signed [thp_pkg::T_W-1:0]    t_out
);
	import thp_pkg::*;

	localparam int PROD_W = INPUT_WIDTH + GAIN_W;
	localparam int SH     = INPUT_WIDTH - 8;
	localparam int TPR_W  = TP_W + 1;
	localparam logic signed [TPR_W-1:0] TP_HALF = TPR_W'(64'sd1 <<< (PI_SHIFT - 1));

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [P_W-1:0]    p_s2;
	logic signed [P_W-1:0]    p_next;
	logic signed [TP_W-1:0]   tp_s3;
	logic signed [T_W-1:0]    t_s4;
	logic                     valid_s1, valid_s2, valid_s3, valid_s4;

	// Round x*gain half up to Q.16
	if (SH > 0) begin : g_round
		localparam int PR_W = PROD_W + 1;
		localparam logic signed [PR_W-1:0] HALF = PR_W'(64'sd1 <<< (SH - 1));
		always_comb begin
			p_next = P_W'((PR_W'(prod_s1) + HALF) >>> SH);
		end
	end else begin : g_exact
		always_comb begin
			p_next = P_W'(prod_s1);
		end
	end

	// Advance the stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Scale by gain, round, multiply by pi, round to t
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1 <= PROD_W'(sample) * PROD_W'(gain);
			p_s2    <= p_next;
			tp_s3   <= TP_W'(p_s2) * TP_W'(PI_Q28);
			t_s4    <= T_W'((TPR_W'(tp_s3) + TP_HALF) >>> PI_SHIFT);
		end
	end

	assign valid_out = valid_s4;
	assign t_out     = t_s4;

endmodule

[rtl/core/thp_cell.sv]
module thp_cell #(
	parameter logic signed [thp_pkg::ACC_W-1:0] COEF = '0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic                              valid_in,
	input  logic signed [thp_pkg::ACC_W-1:0]  acc_in,
	input  logic signed [thp_pkg::T_W-1:0]    t_in,
	output logic                              valid_out,
	output logic signed [thp_pkg::ACC_W-1:0]  acc_out,
	output logic signed [thp_pkg::T_W-1:0]    t_out
);
	import thp_pkg::*;

	localparam int LO_W   = ACC_W / 2;
	localparam int HI_W   = ACC_W - LO_W;
	localparam int PL_W   = LO_W + 1 + T_W;
	localparam int PH_W   = HI_W + T_W;
	localparam int FULL_W = ACC_W + T_W + 1;
	localparam int RND_W  = FULL_W - FRAC;
	localparam int SUM_W  = RND_W + 1;
	localparam logic signed [FULL_W-1:0] HALF = FULL_W'(64'sd1 <<< (FRAC - 1));

	logic signed [LO_W:0]       lo_s;
	logic signed [HI_W-1:0]     hi_s;
	logic signed [PL_W-1:0]     pl_s1;
	logic signed [PH_W-1:0]     ph_s1;
	logic signed [T_W-1:0]      t_s1;
	logic                       valid_s1;
	logic signed [FULL_W-1:0]   full;
	logic signed [RND_W-1:0]    rnd;
	logic signed [SUM_W-1:0]    sum;
	logic signed [ACC_W-1:0]    acc_next;
	logic signed [ACC_W-1:0]    acc_s2;
	logic signed [T_W-1:0]      t_s2;
	logic                       valid_s2;

	// Split the accumulator into an unsigned low half and a signed high half
	always_comb begin
		lo_s = $signed({1'b0, acc_in[LO_W-1:0]});
		hi_s = $signed(acc_in[ACC_W-1:LO_W]);
	end

	// Join partial products, round, add coefficient, saturate
	always_comb begin
		full = (FULL_W'(ph_s1) <<< LO_W) + FULL_W'(pl_s1);
		rnd  = RND_W'((full + HALF) >>> FRAC);
		sum  = SUM_W'(rnd) + SUM_W'(COEF);
		if (sum > SUM_W'(ACC_LIMIT)) begin
			acc_next = ACC_LIMIT;
		end else if (sum < -SUM_W'(ACC_LIMIT)) begin
			acc_next = -ACC_LIMIT;
		end else begin
			acc_next = ACC_W'(sum);
		end
	end

	// Advance the valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	// Partial products, then the finished Horner step
	always_ff @(posedge clk) begin
		if (advance) begin
			pl_s1  <= PL_W'(lo_s) * PL_W'(t_in);
			ph_s1  <= PH_W'(hi_s) * PH_W'(t_in);
			t_s1   <= t_in;
			acc_s2 <= acc_next;
			t_s2   <= t_s1;
		end
	end

	assign valid_out = valid_s2;
	assign acc_out   = acc_s2;
	assign t_out     = t_s2;

endmodule

[rtl/core/tanh_poly_activation_top.sv]
// Polynomial tanh activation. Each sample beat x (signed, INPUT_WIDTH-4 fraction
// bits) gives one result beat: the ninth-order odd polynomial fit of tanh taken at
// t = pi * gain * x, clamped to [-1, 1] and given with OUTPUT_WIDTH-2 fraction bits.
// The block takes one beat every cycle while no result is stalled and returns
// results in order: four stages form t, then a row of nine cells runs one Horner
// step each over two stages (split multiply, then round, add and saturate), and
// one output register clamps and rounds. Back-pressure on the result side stalls
// the whole row and closes the sample side while a result waits; with the output
// register empty the row moves whatever the sink does.
// The gain register (signed Q4.12, 1.0 after reset) is written through
// cfg_wr_en/cfg_wr_data and must only change while no beat is in flight.
module tanh_poly_activation_top #(
	parameter int INPUT_WIDTH  = thp_pkg::DEF_INPUT_WIDTH,
	parameter int OUTPUT_WIDTH = thp_pkg::DEF_OUTPUT_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [thp_pkg::GAIN_W-1:0]        cfg_wr_data,
	thp_sample_if.sink                        in_ch,
	thp_act_if.source                         out_ch
);
	import thp_pkg::*;

	localparam int OUT_FRAC = OUTPUT_WIDTH - 2;

	logic signed [GAIN_W-1:0]       gain_q;
	logic                           advance;
	logic                           out_valid_q;
	logic signed [OUTPUT_WIDTH-1:0] act_q;
	logic signed [OUTPUT_WIDTH-1:0] act_next;
	logic signed [CLAMP_W-1:0]      clamp;

	logic                           valid_c [0:POLY_ORDER];
	logic signed [ACC_W-1:0]        acc_c   [0:POLY_ORDER];
	logic signed [T_W-1:0]          t_c     [0:POLY_ORDER];

	// Whole pipeline moves when the output register is free
	assign advance     = !out_valid_q || out_ch.ready;
	assign in_ch.ready = advance;

	// Gain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_wr_en) begin
			gain_q <= $signed(cfg_wr_data);
		end
	end

	thp_scale #(
		.INPUT_WIDTH (INPUT_WIDTH)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.valid_in  (in_ch.valid),
		.sample    (in_ch.sample_in),
		.gain      (gain_q),
		.valid_out (valid_c[0]),
		.t_out     (t_c[0])
	);

	assign acc_c[0] = COEF_TABLE[0];

	// Horner row, highest power first
	for (genvar i = 1; i <= POLY_ORDER; i++) begin : g_cell
		thp_cell #(
			.COEF (COEF_TABLE[i])
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.valid_in  (valid_c[i-1]),
			.acc_in    (acc_c[i-1]),
			.t_in      (t_c[i-1]),
			.valid_out (valid_c[i]),
			.acc_out   (acc_c[i]),
			.t_out     (t_c[i])
		);
	end

	// Clamp to +-1.0
	always_comb begin
		if (acc_c[POLY_ORDER] > ACC_W'(ONE_Q16)) begin
			clamp = ONE_Q16;
		end else if (acc_c[POLY_ORDER] < -ACC_W'(ONE_Q16)) begin
			clamp = -ONE_Q16;
		end else begin
			clamp = CLAMP_W'(acc_c[POLY_ORDER]);
		end
	end

	// Rescale to the output fraction width
	if (OUT_FRAC < FRAC) begin : g_narrow
		localparam int OSH  = FRAC - OUT_FRAC;
		localparam int CR_W = CLAMP_W + 1;
		localparam logic signed [CR_W-1:0] OHALF = CR_W'(64'sd1 <<< (OSH - 1));
		always_comb begin
			act_next = OUTPUT_WIDTH'((CR_W'(clamp) + OHALF) >>> OSH);
		end
	end else begin : g_wide
		always_comb begin
			act_next = OUTPUT_WIDTH'(clamp) <<< (OUT_FRAC - FRAC);
		end
	end

	// Output register: hold while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_c[POLY_ORDER];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			act_q <= act_next;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.act_out = act_q;

endmodule

[rtl/core/thp_checker.sv]
module thp_checker #(
	parameter int OUTPUT_WIDTH = thp_pkg::DEF_OUTPUT_WIDTH
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [OUTPUT_WIDTH-1:0] act_out
);
	localparam logic signed [OUTPUT_WIDTH-1:0] ONE_OUT =
		OUTPUT_WIDTH'(64'sd1 <<< (OUTPUT_WIDTH - 2));

	// Result beat holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(act_out))
		else $error("result beat dropped or changed under stall");

	// Input side open whenever the output register can move
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("sample side closed with free output register");

	// Input side closed while a result is stalled
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("sample accepted while pipeline stalled");

	// Results stay within +-1.0
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (act_out <= ONE_OUT) && (act_out >= -ONE_OUT))
		else $error("result outside clamp range");

endmodule

bind tanh_poly_activation_top thp_checker #(
	.OUTPUT_WIDTH (OUTPUT_WIDTH)
) u_thp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.act_out   (out_ch.act_out)
);
